// File: design/mvm_pkg.sv
// Package for the multi-voice sample mixer: sizes, state encoding and the
// request type of the shared multiplier. Used by every design file.
// Depends on nothing.
package mvm_pkg;

   localparam int VOICES       = 8;
   localparam int SAMPLE_DEPTH = 65536;
   localparam int VOICE_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int BUSY_W       = $clog2(VOICES + 1);

   // Shared multiplier: signed A times signed B.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Per-voice contribution after the final shift, and the running sum.
   localparam int CONT_W = PROD_W - 24;
   localparam int ACC_W  = CONT_W + VOICE_W + 1;

   localparam logic [15:0] MASTER_GAIN_RESET = 16'd4096;
   localparam logic [16:0] LEN_MAX           = 17'h10000;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_PLAY = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAY,
      ST_CHECK,
      ST_READ1,
      ST_DIFF,
      ST_GAIN,
      ST_MLO,
      ST_MHI,
      ST_SUM,
      ST_ACC,
      ST_MIX,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// File: design/mvm_mul.sv
// Shared signed multiplier with a registered product.
// Every product of the voice datapath goes through this one unit.
// Depends on mvm_pkg.
module mvm_mul (
   input  logic                                clock,
   input  mvm_pkg::mul_req_type                mul_req,
   output logic signed [mvm_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [mvm_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = mvm_pkg::PROD_W'($signed(mul_req.a)) *
                mvm_pkg::PROD_W'($signed(mul_req.b));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: design/mvm_ctrl.sv
// Sequencer, voice table, sample memory and result register of the mixer.
// Walks the voices one at a time through the shared multiplier on a tick.
// Depends on mvm_pkg and works together with mvm_mul.
module mvm_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [15:0]                        req_sample_address,
   input  logic signed [15:0]                 req_sample_value,
   input  logic [16:0]                        req_sound_length,
   input  logic signed [15:0]                 req_voice_gain,
   input  logic [23:0]                        req_pitch_step,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [15:0]                 rsp_mixed_sample,
   output logic                               rsp_play_accepted,
   output logic [2:0]                         rsp_voice_taken,
   output logic [3:0]                         rsp_voices_busy,
   input  logic                               csr_write_en,
   input  logic signed [15:0]                 csr_write_data,
   output mvm_pkg::mul_req_type               mul_req,
   input  logic signed [mvm_pkg::PROD_W-1:0]  mul_prod
);

   localparam int VW = mvm_pkg::VOICE_W;
   localparam int AW = mvm_pkg::ADDR_W;
   localparam int BW = mvm_pkg::BUSY_W;
   localparam int CW = mvm_pkg::CONT_W;
   localparam int SW = mvm_pkg::ACC_W;
   localparam int AM = mvm_pkg::MUL_A_W;
   localparam int BM = mvm_pkg::MUL_B_W;
   localparam int PW = mvm_pkg::PROD_W;

   // Sample memory: written by loads, read one address per cycle.
   logic [15:0]    sample_mem [mvm_pkg::SAMPLE_DEPTH];
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [15:0]    ram_wdata;
   logic           ram_re;
   logic [AW-1:0]  ram_raddr;
   logic [15:0]    ram_rdata_ff;

   // Voice table.
   logic [mvm_pkg::VOICES-1:0] active_ff;
   logic [31:0]               pos_ff   [mvm_pkg::VOICES];
   logic [15:0]               vgain_ff [mvm_pkg::VOICES];
   logic [23:0]               step_ff  [mvm_pkg::VOICES];
   logic [15:0]               start_ff [mvm_pkg::VOICES];
   logic [16:0]               len_ff   [mvm_pkg::VOICES];

   mvm_pkg::state_type state_ff, state_in;
   logic [VW-1:0]        vidx_ff, vidx_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic signed [15:0]   s0_ff, s0_in;
   logic signed [AM-1:0] v_ff, v_in;
   logic [15:0]          ghi_ff, ghi_in;
   logic signed [PW-17:0] pahi_ff, pahi_in;
   logic signed [CW-1:0] cont_ff, cont_in;
   logic [BW-1:0]        busy_ff, busy_in;
   logic [15:0]          master_ff;

   // Captured request.
   logic [15:0] addr_ff;
   logic [16:0] len_req_ff;
   logic [15:0] gain_req_ff;
   logic [23:0] step_req_ff;

   // Result of the item in progress and the output register.
   logic [15:0] mixed_ff, mixed_in;
   logic        accepted_ff, accepted_in;
   logic [2:0]  taken_ff, taken_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_mixed_ff;
   logic        rsp_accepted_ff;
   logic [2:0]  rsp_taken_ff;
   logic [3:0]  rsp_busy_ff;
   logic        rsp_load;

   // Voice table write controls.
   logic          play_we;
   logic [VW-1:0] play_idx;
   logic          free_found;
   logic          clr_we;
   logic          pos_we;
   logic [31:0]   pos_next;

   // Current voice.
   logic [31:0] cur_pos;
   logic [23:0] cur_step;
   logic [15:0] cur_start;
   logic [16:0] cur_len;
   logic [15:0] cur_gain;
   logic [15:0] cur_idx;
   logic [15:0] cur_frac;
   logic        end_hit;
   logic        last_voice;
   logic [32:0] pos_sum;
   logic signed [PW-1:0] mix_sum;
   logic signed [16:0]   diff;
   logic [3:0]  busy_sat;
   logic        accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == mvm_pkg::ST_IDLE);

   assign cur_pos   = pos_ff[vidx_ff];
   assign cur_step  = step_ff[vidx_ff];
   assign cur_start = start_ff[vidx_ff];
   assign cur_len   = len_ff[vidx_ff];
   assign cur_gain  = vgain_ff[vidx_ff];
   assign cur_idx   = cur_pos[31:16];
   assign cur_frac  = cur_pos[15:0];
   assign end_hit   = (17'(cur_idx) + 17'd1) >= cur_len;
   assign last_voice = (vidx_ff == VW'(mvm_pkg::VOICES - 1));
   assign pos_sum   = 33'(cur_pos) + 33'(cur_step);
   assign pos_next  = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
   assign diff      = 17'($signed(ram_rdata_ff)) - 17'(s0_ff);
   assign mix_sum   = mul_prod + PW'(pahi_ff);
   assign busy_sat  = (32'(busy_ff) > 32'd15) ? 4'd15 : 4'(busy_ff);

   // Lowest free voice.
   always_comb begin
      free_found = 1'b0;
      play_idx   = '0;
      for (int i = mvm_pkg::VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            play_idx   = VW'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      vidx_in     = vidx_ff;
      acc_in      = acc_ff;
      s0_in       = s0_ff;
      v_in        = v_ff;
      ghi_in      = ghi_ff;
      pahi_in     = pahi_ff;
      cont_in     = cont_ff;
      busy_in     = busy_ff;
      mixed_in    = mixed_ff;
      accepted_in = accepted_ff;
      taken_in    = taken_ff;
      ram_we      = 1'b0;
      ram_waddr   = AW'(32'(req_sample_address));
      ram_wdata   = req_sample_value;
      ram_re      = 1'b0;
      ram_raddr   = AW'(32'(cur_start) + 32'(cur_idx));
      play_we     = 1'b0;
      clr_we      = 1'b0;
      pos_we      = 1'b0;
      rsp_load    = 1'b0;
      mul_req.a   = AM'($signed(diff));
      mul_req.b   = {1'b0, cur_frac};

      unique case (state_ff)
         mvm_pkg::ST_IDLE: begin
            if (accept) begin
               mixed_in    = '0;
               accepted_in = 1'b0;
               taken_in    = '0;
               vidx_in     = '0;
               acc_in      = '0;
               unique case (mvm_pkg::action_type'(req_action))
                  mvm_pkg::ACT_LOAD: begin
                     ram_we   = 1'b1;
                     state_in = mvm_pkg::ST_FINISH;
                  end
                  mvm_pkg::ACT_PLAY: state_in = mvm_pkg::ST_PLAY;
                  mvm_pkg::ACT_TICK: state_in = mvm_pkg::ST_CHECK;
                  default:           state_in = mvm_pkg::ST_FINISH;
               endcase
            end
         end
         mvm_pkg::ST_PLAY: begin
            if (len_req_ff != '0 && free_found) begin
               play_we     = 1'b1;
               busy_in     = busy_ff + BW'(1);
               accepted_in = 1'b1;
               taken_in    = 3'(play_idx);
            end
            state_in = mvm_pkg::ST_FINISH;
         end
         mvm_pkg::ST_CHECK: begin
            if (active_ff[vidx_ff] && !end_hit) begin
               ram_re   = 1'b1;
               state_in = mvm_pkg::ST_READ1;
            end else begin
               if (active_ff[vidx_ff]) begin
                  clr_we  = 1'b1;
                  busy_in = busy_ff - BW'(1);
               end
               if (last_voice) begin
                  state_in = mvm_pkg::ST_MIX;
               end else begin
                  vidx_in = vidx_ff + VW'(1);
               end
            end
         end
         mvm_pkg::ST_READ1: begin
            s0_in     = $signed(ram_rdata_ff);
            ram_re    = 1'b1;
            ram_raddr = AW'(32'(cur_start) + 32'(cur_idx) + 32'd1);
            state_in  = mvm_pkg::ST_DIFF;
         end
         mvm_pkg::ST_DIFF: begin
            // (s1 - s0) times the position fraction.
            state_in = mvm_pkg::ST_GAIN;
         end
         mvm_pkg::ST_GAIN: begin
            v_in      = (AM'(s0_ff) <<< 16) + mul_prod[AM-1:0];
            mul_req.a = AM'($signed(cur_gain));
            mul_req.b = BM'($signed(master_ff));
            state_in  = mvm_pkg::ST_MLO;
         end
         mvm_pkg::ST_MLO: begin
            // The 32-bit gain product is split in halves for the wide multiply.
            ghi_in    = mul_prod[31:16];
            mul_req.a = v_ff;
            mul_req.b = {1'b0, mul_prod[15:0]};
            state_in  = mvm_pkg::ST_MHI;
         end
         mvm_pkg::ST_MHI: begin
            pahi_in   = mul_prod[PW-1:16];
            mul_req.a = v_ff;
            mul_req.b = BM'($signed(ghi_ff));
            state_in  = mvm_pkg::ST_SUM;
         end
         mvm_pkg::ST_SUM: begin
            // The low 16 bits of the low partial product never reach the
            // integer part, so a floor shift of the aligned sum is exact.
            cont_in  = mix_sum[PW-1:24];
            state_in = mvm_pkg::ST_ACC;
         end
         mvm_pkg::ST_ACC: begin
            acc_in = acc_ff + SW'(cont_ff);
            pos_we = 1'b1;
            if (last_voice) begin
               state_in = mvm_pkg::ST_MIX;
            end else begin
               vidx_in  = vidx_ff + VW'(1);
               state_in = mvm_pkg::ST_CHECK;
            end
         end
         mvm_pkg::ST_MIX: begin
            if (acc_ff > SW'(32767)) begin
               mixed_in = 16'h7FFF;
            end else if (acc_ff < -SW'(32768)) begin
               mixed_in = 16'h8000;
            end else begin
               mixed_in = acc_ff[15:0];
            end
            state_in = mvm_pkg::ST_FINISH;
         end
         mvm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = mvm_pkg::ST_IDLE;
            end
         end
         default: state_in = mvm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvm_pkg::ST_IDLE;
         active_ff    <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         master_ff    <= mvm_pkg::MASTER_GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            master_ff <= csr_write_data;
         end
         if (play_we) begin
            active_ff[play_idx] <= 1'b1;
         end
         if (clr_we) begin
            active_ff[vidx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff     <= vidx_in;
      acc_ff      <= acc_in;
      s0_ff       <= s0_in;
      v_ff        <= v_in;
      ghi_ff      <= ghi_in;
      pahi_ff     <= pahi_in;
      cont_ff     <= cont_in;
      mixed_ff    <= mixed_in;
      accepted_ff <= accepted_in;
      taken_ff    <= taken_in;
      if (accept) begin
         addr_ff     <= req_sample_address;
         len_req_ff  <= req_sound_length;
         gain_req_ff <= req_voice_gain;
         step_req_ff <= req_pitch_step;
      end
      if (play_we) begin
         pos_ff[play_idx]   <= '0;
         vgain_ff[play_idx] <= gain_req_ff;
         step_ff[play_idx]  <= step_req_ff;
         start_ff[play_idx] <= addr_ff;
         len_ff[play_idx]   <= len_req_ff[16] ? mvm_pkg::LEN_MAX : len_req_ff;
      end
      if (pos_we) begin
         pos_ff[vidx_ff] <= pos_next;
      end
      if (rsp_load) begin
         rsp_mixed_ff    <= mixed_ff;
         rsp_accepted_ff <= accepted_ff;
         rsp_taken_ff    <= taken_ff;
         rsp_busy_ff     <= busy_sat;
      end
   end

   // Sample memory ports.
   always_ff @(posedge clock) begin
      if (ram_we) begin
         sample_mem[ram_waddr] <= ram_wdata;
      end
      if (ram_re) begin
         ram_rdata_ff <= sample_mem[ram_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mixed_sample  = $signed(rsp_mixed_ff);
   assign rsp_play_accepted = rsp_accepted_ff;
   assign rsp_voice_taken   = rsp_taken_ff;
   assign rsp_voices_busy   = rsp_busy_ff;

endmodule

// File: design/multi_voice_sample_mixer.sv
// Top level of the multi-voice wavetable mixer.
// Joins the sequencer with its sample memory and the shared multiplier.
// Depends on mvm_pkg, mvm_mul and mvm_ctrl.
//
// Usage: items enter on the req_ channel (valid/ready) and each produces
// exactly one result on the rsp_ channel (valid/ready). A load writes one
// sample word, a play claims the lowest free voice, a tick mixes one frame.
// master_gain is written through csr_write_en/csr_write_data while idle.
// A tick walks all voices in turn; an idle or ending voice is only checked.
// The time a tick takes is set by the one shared multiplier, used four
// times per sounding voice, and by the single read port of the sample
// memory, read twice per sounding voice.
// A result sits in an output register; the next item is taken while it
// waits, and that item stalls in its last cycle until the receiver takes
// the earlier transfer. Reset empties the voice pool, clears the output
// valid and sets master gain to 1.0; sample memory is not cleared and must
// be loaded before a voice reads it.
module multi_voice_sample_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [15:0]        req_sample_address,
   input  logic signed [15:0] req_sample_value,
   input  logic [16:0]        req_sound_length,
   input  logic signed [15:0] req_voice_gain,
   input  logic [23:0]        req_pitch_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_play_accepted,
   output logic [2:0]         rsp_voice_taken,
   output logic [3:0]         rsp_voices_busy,
   input  logic               csr_write_en,
   input  logic signed [15:0] csr_write_data
);

   mvm_pkg::mul_req_type                mul_req;
   logic signed [mvm_pkg::PROD_W-1:0]   mul_prod;

   mvm_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_sample_address (req_sample_address),
      .req_sample_value   (req_sample_value),
      .req_sound_length   (req_sound_length),
      .req_voice_gain     (req_voice_gain),
      .req_pitch_step     (req_pitch_step),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .rsp_play_accepted  (rsp_play_accepted),
      .rsp_voice_taken    (rsp_voice_taken),
      .rsp_voices_busy    (rsp_voices_busy),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .mul_req            (mul_req),
      .mul_prod           (mul_prod)
   );

   mvm_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (mul_prod)
   );

endmodule

// File: design/mvm_checker.sv
// Port-level checks for the multi-voice sample mixer, bound to its top level.
// Depends on mvm_pkg and on the top level's port list.
module mvm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_mixed_sample,
   input logic               rsp_play_accepted,
   input logic [2:0]         rsp_voice_taken,
   input logic [3:0]         rsp_voices_busy
);

   // A held result keeps its payload until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mixed_sample) &&
      $stable(rsp_voices_busy))
      else $error("held result changed before transfer");

   // Every item leaves the idle state on acceptance, so ready drops after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on two consecutive cycles");

   // A claimed voice never comes with a mixed frame; a dropped play names none.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_play_accepted || rsp_mixed_sample == 16'sd0) &&
      (rsp_play_accepted || rsp_voice_taken == 3'd0))
      else $error("result fields inconsistent");

   // The busy count can never exceed the pool.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_voices_busy) <= mvm_pkg::VOICES)
      else $error("busy count above voice pool");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multi_voice_sample_mixer mvm_checker u_mvm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_mixed_sample  (rsp_mixed_sample),
   .rsp_play_accepted (rsp_play_accepted),
   .rsp_voice_taken   (rsp_voice_taken),
   .rsp_voices_busy   (rsp_voices_busy)
);

// File: tb/multi_voice_sample_mixer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_voice_sample_mixer: random and directed
// load, play and tick traffic against a built-in mixer scoreboard.
// Depends on mvm_pkg and the multi_voice_sample_mixer RTL.
module multi_voice_sample_mixer_test;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASE_ITEMS  = 270;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      mvm_pkg::action_type action;
      bit [15:0]           address;
      bit signed [15:0]    value;
      bit [16:0]           span;
      bit signed [15:0]    gain;
      bit [23:0]           step;
   } mixer_request_type;

   typedef struct packed {
      logic signed [15:0] mixed;
      logic               accepted;
      logic [2:0]         voice;
      logic [3:0]         busy;
   } mixer_outcome_type;

   // Tracks the sample store and voice pool, and queues the outcome of
   // every accepted request until the matching response transfer arrives.
   class mixer_scoreboard_type;
      bit signed [15:0]  samples [mvm_pkg::SAMPLE_DEPTH];
      bit                loaded [mvm_pkg::SAMPLE_DEPTH];
      bit                active [mvm_pkg::VOICES];
      bit [31:0]         position [mvm_pkg::VOICES];
      bit signed [15:0]  voice_gain [mvm_pkg::VOICES];
      bit [23:0]         voice_step [mvm_pkg::VOICES];
      bit [15:0]         voice_start [mvm_pkg::VOICES];
      bit [16:0]         voice_len [mvm_pkg::VOICES];
      bit signed [15:0]  master = mvm_pkg::MASTER_GAIN_RESET;
      mixer_outcome_type outputs_due [$];
      int                errors;

      function void note_request(mixer_request_type r);
         mixer_outcome_type due;
         longint total, s0, s1, blend, scale;
         int idx, busy;
         bit [15:0] a;
         bit [32:0] next_pos;
         due = '0;
         total = 0;
         case (r.action)
            mvm_pkg::ACT_LOAD: begin
               samples[r.address] = r.value;
               loaded[r.address] = 1'b1;
            end
            mvm_pkg::ACT_PLAY: begin
               if (r.span != 0) begin
                  for (int v = 0; v < mvm_pkg::VOICES; v++) begin
                     if (!active[v] && !due.accepted) begin
                        active[v] = 1'b1;
                        position[v] = '0;
                        voice_gain[v] = r.gain;
                        voice_step[v] = r.step;
                        voice_start[v] = r.address;
                        voice_len[v] = (r.span > mvm_pkg::LEN_MAX) ?
                                       mvm_pkg::LEN_MAX : r.span;
                        due.accepted = 1'b1;
                        due.voice = 3'(v);
                     end
                  end
               end
            end
            mvm_pkg::ACT_TICK: begin
               for (int v = 0; v < mvm_pkg::VOICES; v++) begin
                  if (active[v]) begin
                     idx = position[v][31:16];
                     if (idx + 1 >= int'(voice_len[v])) begin
                        active[v] = 1'b0;
                     end else begin
                        a = voice_start[v] + idx;
                        s0 = longint'(samples[a]);
                        a = a + 16'd1;
                        s1 = longint'(samples[a]);
                        blend = s0 * 65536 + (s1 - s0) * longint'(position[v][15:0]);
                        scale = longint'(voice_gain[v]) * longint'(master);
                        // Q1.31 times Q8.24, floored back to Q1.15.
                        total += (blend * scale) >>> 40;
                        next_pos = position[v] + voice_step[v];
                        position[v] = next_pos[32] ? 32'hFFFF_FFFF : next_pos[31:0];
                     end
                  end
               end
               if (total > 32767) total = 32767;
               else if (total < -32768) total = -32768;
               due.mixed = total[15:0];
            end
            default: ;
         endcase
         busy = 0;
         for (int v = 0; v < mvm_pkg::VOICES; v++) busy += active[v];
         due.busy = 4'(busy);
         outputs_due.push_back(due);
      endfunction

      function void check_response(mixer_outcome_type got);
         mixer_outcome_type want;
         if (outputs_due.size() == 0) begin
            $display("%0t: response with nothing pending: mixed %0d accepted %0b voice %0d busy %0d",
                     $time, got.mixed, got.accepted, got.voice, got.busy);
            errors++;
            return;
         end
         want = outputs_due.pop_front();
         if (got.mixed !== want.mixed || got.accepted !== want.accepted ||
             got.voice !== want.voice || got.busy !== want.busy) begin
            $display("%0t: expected mixed %0d accepted %0b voice %0d busy %0d", $time,
                     want.mixed, want.accepted, want.voice, want.busy);
            $display("%0t:   actual mixed %0d accepted %0b voice %0d busy %0d", $time,
                     got.mixed, got.accepted, got.voice, got.busy);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = mvm_pkg::ACT_NONE;
   logic [15:0]        req_sample_address = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [16:0]        req_sound_length = '0;
   logic signed [15:0] req_voice_gain = '0;
   logic [23:0]        req_pitch_step = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_mixed_sample;
   logic               rsp_play_accepted;
   logic [2:0]         rsp_voice_taken;
   logic [3:0]         rsp_voices_busy;
   logic               csr_write_en = 1'b0;
   logic signed [15:0] csr_write_data = '0;

   mixer_scoreboard_type sb;
   bit  calm;
   int  items_sent;
   int  stall_left;
   int  cycle_count;

   multi_voice_sample_mixer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_sample_address(req_sample_address),
      .req_sample_value  (req_sample_value),
      .req_sound_length  (req_sound_length),
      .req_voice_gain    (req_voice_gain),
      .req_pitch_step    (req_pitch_step),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mixed_sample  (rsp_mixed_sample),
      .rsp_play_accepted (rsp_play_accepted),
      .rsp_voice_taken   (rsp_voice_taken),
      .rsp_voices_busy   (rsp_voices_busy),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Fields that the action ignores still carry random bits.
   function automatic mixer_request_type scrambled_request();
      mixer_request_type r;
      r.action = mvm_pkg::ACT_NONE;
      r.address = $urandom;
      r.value = $urandom;
      r.span = $urandom_range(0, 17'h1FFFF);
      r.gain = $urandom;
      r.step = $urandom;
      return r;
   endfunction

   // Response side: check each transfer, then decide next cycle's ready.
   always @(posedge clock) begin : response_side
      mixer_outcome_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.mixed = rsp_mixed_sample;
         seen.accepted = rsp_play_accepted;
         seen.voice = rsp_voice_taken;
         seen.busy = rsp_voices_busy;
         sb.check_response(seen);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Returns at the clock edge of the transfer, with valid still high.
   task automatic send_item(input mixer_request_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.action;
      req_sample_address <= r.address;
      req_sample_value <= r.value;
      req_sound_length <= r.span;
      req_voice_gain <= r.gain;
      req_pitch_step <= r.step;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      items_sent++;
   endtask

   task automatic send_load(input bit [15:0] address, input bit [15:0] value);
      mixer_request_type r;
      r = scrambled_request();
      r.action = mvm_pkg::ACT_LOAD;
      r.address = address;
      r.value = value;
      send_item(r);
   endtask

   task automatic send_play(input bit [15:0] start, input int span,
                            input bit [15:0] gain, input bit [23:0] step);
      mixer_request_type r;
      r = scrambled_request();
      r.action = mvm_pkg::ACT_PLAY;
      r.address = start;
      r.span = span;
      r.gain = gain;
      r.step = step;
      send_item(r);
   endtask

   // The memory is never read before it is written, so any word that a
   // sounding voice will fetch on this tick gets loaded first.
   task automatic send_tick();
      mixer_request_type r;
      bit [15:0] a;
      int idx;
      for (int v = 0; v < mvm_pkg::VOICES; v++) begin
         idx = sb.position[v][31:16];
         if (sb.active[v] && idx + 1 < int'(sb.voice_len[v])) begin
            for (int k = 0; k < 2; k++) begin
               a = sb.voice_start[v] + idx + k;
               if (!sb.loaded[a]) send_load(a, $urandom);
            end
         end
      end
      r = scrambled_request();
      r.action = mvm_pkg::ACT_TICK;
      send_item(r);
   endtask

   // Lengths are paired with steps so that most voices end within a few
   // dozen ticks; voices held by a zero pitch are kept to a couple.
   task automatic random_play();
      int pick, held, span, lo;
      bit [23:0] step;
      bit [15:0] gain;
      held = 0;
      for (int v = 0; v < mvm_pkg::VOICES; v++)
         if (sb.active[v] && sb.voice_step[v] == 0 && sb.voice_len[v] > 1) held++;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         span = 0;
         step = $urandom;
      end else if (pick < 10) begin
         span = 1;
         step = $urandom;
      end else if (pick < 11) begin
         span = $urandom_range(0, 1) ? 65536 : $urandom_range(65537, 131071);
         step = $urandom_range(24'hF00000, 24'hFFFFFF);
      end else if (pick < 23) begin
         span = $urandom_range(64, 4096);
         step = $urandom_range(span * 2048, 24'hFFFFFF);
      end else if (pick < 25 && held < 2) begin
         span = $urandom_range(2, 8);
         step = '0;
      end else begin
         span = $urandom_range(2, 40);
         lo = span * 2048;
         step = $urandom_range(lo, lo * 4);
      end
      pick = $urandom_range(0, 9);
      gain = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'($urandom);
      send_play($urandom, span, gain, step);
   endtask

   task automatic write_master_gain(input bit [15:0] gain);
      req_valid <= 1'b0;
      while (sb.outputs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= gain;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.master = gain;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      bit [15:0] gains [6];
      mixer_request_type r;
      int pick, target, burst;
      bit [15:0] base;
      sb = new;
      gains = '{mvm_pkg::MASTER_GAIN_RESET, 16'h7FFF, 16'h8000, 16'h0000,
                16'($urandom), 16'h0800};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: full-scale words, an interpolated voice, an address
      // wrap, dropped and one-sample sounds, an overlong sound at the top
      // pitch, a held voice, a no-op, then enough plays to fill the pool.
      send_load(16'h0000, 16'h7FFF);
      send_load(16'h0001, 16'h8000);
      send_load(16'hFFFF, 16'h8000);
      send_load(16'h0002, 16'h7FFF);
      send_play(16'h0000, 2, 16'h7FFF, 24'h008000);
      send_play(16'hFFFF, 3, 16'h8000, 24'h010000);
      send_play(16'h0005, 0, 16'h1000, 24'h010000);
      send_play(16'h0007, 1, 16'h1000, 24'h010000);
      send_tick();
      send_play(16'h0100, 17'h1FFFF, 16'h7FFF, 24'hFFFFFF);
      send_play(16'h0000, 2, 16'h1000, 24'h000000);
      r = scrambled_request();
      r.address = '1;
      r.value = '1;
      r.span = '1;
      r.gain = '1;
      r.step = '1;
      send_item(r);
      send_tick();
      send_tick();
      repeat (6) send_play(16'h0000, 3, $urandom, 24'h004000);
      send_tick();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) write_master_gain(gains[phase]);
         calm = (phase == 4);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               base = $urandom;
               burst = $urandom_range(2, 8);
               for (int k = 0; k < burst; k++) begin
                  pick = $urandom_range(0, 9);
                  send_load(base + k, (pick == 0) ? 16'h7FFF :
                                      (pick == 1) ? 16'h8000 : 16'($urandom));
               end
            end else if (pick < 45) begin
               random_play();
            end else if (pick < 95) begin
               send_tick();
            end else begin
               r = scrambled_request();
               send_item(r);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.outputs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outputs_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
